@@ rtl/pcmf_pkg.sv @@
package pcmf_pkg;

    // Sample encodings held in the encoding register.
    typedef enum logic [2:0] {
        ENC_INT16   = 3'd0,
        ENC_PACK24  = 3'd1,
        ENC_IN32_24 = 3'd2,
        ENC_INT32   = 3'd3,
        ENC_FLOAT32 = 3'd4
    } enc_t;

    // Register indexes on the configuration port.
    localparam logic REG_ENCODING = 1'b0;
    localparam logic REG_CHANNELS = 1'b1;

    localparam logic [3:0] MONO_CHANNELS = 4'd1;
    localparam logic [3:0] RESET_CHANNELS = 4'd2;

    // Values after the front stage of a lane: sign, magnitude and scale.
    typedef struct packed {
        logic        zero;
        logic        pass;
        logic        sign;
        logic [31:0] mag;
        logic [4:0]  shift;
        logic [31:0] raw;
    } lane_mid_t;

endpackage

@@ rtl/pcmf_lane.sv @@
module pcmf_lane
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [2:0]           encoding,
    input  logic [31:0]          word,
    output logic [31:0]          result
);
    import pcmf_pkg::*;

    lane_mid_t mid_next;
    lane_mid_t mid_reg;
    logic signed [32:0] sval;
    logic [4:0]  msb;
    logic [31:0] norm;
    logic        rnd_up;
    logic [24:0] mant;
    logic [8:0]  expo;
    logic [31:0] fbits;

    // Front stage: pick the signed value and its power-of-two scale.
    always_comb
    begin
        sval = '0;
        mid_next.shift = 5'd31;
        mid_next.pass = 1'b0;
        mid_next.raw = word;
        case (encoding)
            ENC_INT16:
            begin
                sval = 33'(signed'(word[15:0]));
                mid_next.shift = 5'd15;
            end
            ENC_PACK24:
            begin
                sval = 33'(signed'(word[23:0]));
                mid_next.shift = 5'd23;
            end
            ENC_IN32_24:
            begin
                sval = 33'(signed'(word));
                if (word[31:23] == 9'h000 || word[31:23] == 9'h1FF)
                begin
                    mid_next.shift = 5'd23;
                end
            end
            ENC_INT32:
            begin
                sval = 33'(signed'(word));
            end
            ENC_FLOAT32:
            begin
                mid_next.pass = 1'b1;
            end
            default:
            begin
                mid_next.raw = '0;
                mid_next.pass = 1'b1;
            end
        endcase
        mid_next.sign = sval[32];
        mid_next.mag = sval[32] ? 32'(-sval) : sval[31:0];
        mid_next.zero = (sval == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
        end
        else if (en)
        begin
            mid_reg <= mid_next;
        end
    end

    // Back stage: normalise, round to nearest even and assemble the bits.
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (mid_reg.mag[i])
            begin
                msb = 5'(i);
            end
        end
        norm = mid_reg.mag << (5'd31 - msb);
        rnd_up = norm[7] && (norm[6:0] != '0 || norm[8]);
        mant = {1'b0, norm[31:8]} + 25'(rnd_up);
        expo = 9'(msb) + 9'd127 - 9'(mid_reg.shift);
        if (mant[24])
        begin
            expo = expo + 9'd1;
        end
        fbits = {mid_reg.sign, expo[7:0], mant[24] ? mant[23:1] : mant[22:0]};
        if (mid_reg.pass)
        begin
            result = mid_reg.raw;
        end
        else if (mid_reg.zero)
        begin
            result = '0;
        end
        else
        begin
            result = fbits;
        end
    end

endmodule

@@ rtl/pcm_frame_to_stereo_float_core.sv @@
// An accepted input passes the lane front-stage register, then the output register.
// Throughput: one frame per cycle if not stalled; both lanes convert in parallel,
// each a two-stage pipeline (sign and scale selection, then normalise and round).
// Reset: asynchronous, active low; encoding returns to int16, channel count to
// two, and the pipeline empties.
module pcm_frame_to_stereo_float_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // first_channel_word, second_channel_word
    input  logic        s_axis_tlast,  // frame_is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // left_float_bits, right_float_bits
    output logic        m_axis_tlast   // result_is_last
);
    import pcmf_pkg::*;

    logic [2:0]  enc_reg;
    logic [3:0]  chan_reg;
    logic        v1_reg, v2_reg;
    logic        l1_reg, l2_reg;
    logic        mono1_reg;
    logic        adv;
    logic        wr;
    logic [31:0] left_bits, right_bits;
    logic [31:0] res_l_reg, res_r_reg;

    // Configuration registers.
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg <= ENC_INT16;
            chan_reg <= RESET_CHANNELS;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == REG_ENCODING)
            begin
                enc_reg <= pwdata[2:0];
            end
            else if (paddr[2] == REG_CHANNELS)
            begin
                chan_reg <= pwdata[3:0];
            end
        end
    end
    assign prdata = (paddr[2] == REG_CHANNELS) ? {28'd0, chan_reg} : {29'd0, enc_reg};

    // The whole pipeline advances when the output stage is free or drains.
    assign adv = !v2_reg || m_axis_tready;
    assign s_axis_tready = adv;

    pcmf_lane u_lane_l
    (
        .clk(clk), .rst_n(rst_n), .en(adv), .encoding(enc_reg),
        .word(s_axis_tdata[31:0]), .result(left_bits)
    );
    pcmf_lane u_lane_r
    (
        .clk(clk), .rst_n(rst_n), .en(adv), .encoding(enc_reg),
        .word(s_axis_tdata[63:32]), .result(right_bits)
    );

    // Pipeline control and merging stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l1_reg <= s_axis_tlast;
            mono1_reg <= (chan_reg == MONO_CHANNELS);
            l2_reg <= l1_reg;
            res_l_reg <= left_bits;
            res_r_reg <= mono1_reg ? left_bits : right_bits;
        end
    end

    assign m_axis_tvalid = v2_reg;
    assign m_axis_tdata = {res_r_reg, res_l_reg};
    assign m_axis_tlast = l2_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output dropped while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v1_reg)
        else $error("accepted transaction lost");

endmodule
